// ----- rtl/ptp_pkg.sv -----
// Package for the perceptron train/predict unit: widths, reset values and op codes.
`default_nettype none
package ptp_pkg;

  localparam int NUM_INPUTS_DEF = 16;

  localparam int W_WIDTH    = 32;  // weight, signed Q8.24
  localparam int F_WIDTH    = 16;  // feature, signed Q8.8
  localparam int RATE_WIDTH = 16;  // learning rate, unsigned Q0.16
  localparam int SUM_WIDTH  = 64;  // exact Q32.32 accumulator
  localparam int PROD_WIDTH = W_WIDTH + F_WIDTH;
  localparam int STEP_WIDTH = RATE_WIDTH + F_WIDTH + 1;  // rate * feature, signed
  localparam int NV_WIDTH   = W_WIDTH + 4;               // weight plus step, no overflow

  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 16'd66;
  localparam logic signed [F_WIDTH-1:0] ONE_Q8_8 = 16'sd256;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  localparam logic CLASS_NEG = 1'b0;
  localparam logic CLASS_POS = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/perceptron_train_predict_unit.sv -----
// Perceptron with bias: streaming dot product, sign decision and saturating Rosenblatt update.
`default_nettype none
// Features of one sample arrive one per input transfer and are summed as they
// come; the transfer marked last yields one result (class before update,
// weights changed, any weight clipped). Each feature passes through a read of
// its weight from the weight memory and a registered multiply; the product
// is then added into the running sum. A last transfer steps through weight
// read, multiply with bias read, product add, bias add, decision and result
// load; when its feature lies beyond NUM_INPUTS, the multiply is skipped and
// the bias is read at once. A result still waiting in the output register
// holds the unit in the result load. When op asks for training and the class
// is wrong, the update walks the n buffered features and the bias one weight
// per cycle through a three-stage read/multiply/write pipeline on the weight
// memory, between decision and result load. Weights start at zero after
// reset through per-entry valid bits, so no clearing pass is needed.
// learning_rate may be written only while the unit is idle. Features beyond
// NUM_INPUTS in one sample are ignored.
module perceptron_train_predict_unit #(
  parameter int NUM_INPUTS = ptp_pkg::NUM_INPUTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [ptp_pkg::RATE_WIDTH-1:0]        cfg_wdata,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  op,
  input  wire logic signed [ptp_pkg::F_WIDTH-1:0]    feature,
  input  wire logic                                  label,
  input  wire logic                                  last,
  // output channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       predicted_class,
  output logic                                       weights_changed,
  output logic                                       saturated
);
  import ptp_pkg::*;

  localparam int CW     = $clog2(NUM_INPUTS + 1);
  localparam int FW     = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int WDEPTH = NUM_INPUTS + 1;
  localparam logic [CW-1:0] BIAS_IDX = CW'(NUM_INPUTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_BRD  = 3'd2;
  localparam logic [2:0] S_BADD = 3'd3;
  localparam logic [2:0] S_CLS  = 3'd4;
  localparam logic [2:0] S_TRN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // control state
  logic [2:0]                  state;
  logic [CW-1:0]               count;
  logic [CW-1:0]               idx;
  logic                        iss_active;
  logic                        prod_pend;
  logic                        s1_valid;
  logic                        s2_valid;
  logic [RATE_WIDTH-1:0]       learning_rate;
  logic signed [SUM_WIDTH-1:0] sum;
  logic                        chg;
  logic                        sat;

  // payload registers
  logic                         op_q;
  logic                         label_q;
  logic                         last_q;
  logic                         cls_q;
  logic signed [F_WIDTH-1:0]    x_q;
  logic signed [PROD_WIDTH-1:0] prod;
  logic                         s1_bias;
  logic [CW-1:0]                s1_addr;
  logic                         s2_bias;
  logic [CW-1:0]                s2_addr;
  logic signed [W_WIDTH-1:0]    s2_w;
  logic signed [NV_WIDTH-1:0]   s2_delta;

  // memories
  logic signed [W_WIDTH-1:0] wmem [WDEPTH];
  logic [WDEPTH-1:0]         wvalid;
  logic signed [W_WIDTH-1:0] w_rdata;
  logic                      w_rvalid;
  logic signed [F_WIDTH-1:0] fbuf [NUM_INPUTS];
  logic signed [F_WIDTH-1:0] f_rdata;

  // combinational
  logic                         accept;
  logic                         room;
  logic                         w_rd_en;
  logic [CW-1:0]                w_raddr;
  logic                         f_rd_en;
  logic signed [W_WIDTH-1:0]    w_eff;
  logic signed [F_WIDTH-1:0]    fval;
  logic signed [STEP_WIDTH-1:0] step;
  logic signed [NV_WIDTH-1:0]   step2;
  logic signed [NV_WIDTH-1:0]   nv;
  logic                         clip;
  logic signed [W_WIDTH-1:0]    wnew;
  logic                         cls_now;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign room     = (count < BIAS_IDX);
  assign w_eff    = w_rvalid ? w_rdata : '0;
  assign cls_now  = sum[SUM_WIDTH-1] ? CLASS_NEG : CLASS_POS;

  // select the weight memory read address
  always_comb begin
    w_rd_en = 1'b0;
    w_raddr = BIAS_IDX;
    f_rd_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        w_rd_en = accept && (room || last);
        w_raddr = room ? count : BIAS_IDX;
      end
      S_MUL: begin
        w_rd_en = last_q;
      end
      S_TRN: begin
        w_rd_en = iss_active;
        w_raddr = idx;
        f_rd_en = iss_active && (idx != BIAS_IDX);
      end
      default: begin
        w_rd_en = 1'b0;
      end
    endcase
  end

  // training step: rate * feature * (label - class)
  always_comb begin
    fval  = s1_bias ? ONE_Q8_8 : f_rdata;
    step  = $signed({1'b0, learning_rate}) * fval;
    step2 = {{(NV_WIDTH - STEP_WIDTH - 1){step[STEP_WIDTH-1]}}, step, 1'b0};
  end

  // add, saturate
  always_comb begin
    nv   = {{(NV_WIDTH - W_WIDTH){s2_w[W_WIDTH-1]}}, s2_w} + s2_delta;
    clip = (nv[NV_WIDTH-1:W_WIDTH-1] != {(NV_WIDTH - W_WIDTH + 1){nv[NV_WIDTH-1]}});
    if (!clip) begin
      wnew = nv[W_WIDTH-1:0];
    end else if (nv[NV_WIDTH-1]) begin
      wnew = {1'b1, {(W_WIDTH - 1){1'b0}}};
    end else begin
      wnew = {1'b0, {(W_WIDTH - 1){1'b1}}};
    end
  end

  // weight memory: registered read, write from the last training stage
  always_ff @(posedge clk) begin
    if (w_rd_en) begin
      w_rdata  <= wmem[w_raddr];
      w_rvalid <= wvalid[w_raddr];
    end
    if (s2_valid) begin
      wmem[s2_addr] <= wnew;
    end
  end

  // mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (s2_valid) begin
      wvalid[s2_addr] <= 1'b1;
    end
  end

  // feature buffer
  always_ff @(posedge clk) begin
    if (accept && room) begin
      fbuf[count[FW-1:0]] <= feature;
    end
    if (f_rd_en) begin
      f_rdata <= fbuf[idx[FW-1:0]];
    end
  end

  // learning rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= RATE_RESET;
    end else if (cfg_we) begin
      learning_rate <= cfg_wdata;
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      label_q <= label;
      last_q  <= last;
      x_q     <= feature;
    end
    if (state == S_MUL) begin
      prod <= w_eff * x_q;
    end
    if (state == S_CLS) begin
      cls_q <= cls_now;
    end
    s1_bias  <= (idx == BIAS_IDX);
    s1_addr  <= idx;
    s2_bias  <= s1_bias;
    s2_addr  <= s1_addr;
    s2_w     <= w_eff;
    s2_delta <= label_q ? step2 : -step2;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      predicted_class <= cls_q;
      weights_changed <= chg;
      saturated       <= sat;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      iss_active <= 1'b0;
      prod_pend  <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      sum        <= '0;
      chg        <= 1'b0;
      sat        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_valid  <= (state == S_TRN) && iss_active;
      s2_valid  <= s1_valid;
      prod_pend <= (state == S_MUL);

      // load a result when the register frees, drop a taken one
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // accumulate the dot product
      if (prod_pend) begin
        sum <= sum + {{(SUM_WIDTH - PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};
      end else if (state == S_BADD) begin
        sum <= sum + {{(SUM_WIDTH - W_WIDTH - 8){w_eff[W_WIDTH-1]}}, w_eff, 8'b0};
      end else if (state == S_CLS) begin
        sum <= '0;
      end

      // collect update flags
      if (s2_valid) begin
        if (wnew != s2_w) begin
          chg <= 1'b1;
        end
        if (clip) begin
          sat <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              count <= count + 1'b1;
              state <= S_MUL;
            end else if (last) begin
              state <= S_BRD;
            end
          end
        end
        S_MUL: begin
          state <= last_q ? S_BRD : S_IDLE;
        end
        S_BRD: begin
          state <= S_BADD;
        end
        S_BADD: begin
          state <= S_CLS;
        end
        S_CLS: begin
          chg <= 1'b0;
          sat <= 1'b0;
          if (op_q == OP_TRAIN && label_q != cls_now) begin
            idx        <= (count == '0) ? BIAS_IDX : '0;
            iss_active <= 1'b1;
            state      <= S_TRN;
          end else begin
            state <= S_OUT;
          end
        end
        S_TRN: begin
          // advance the issue index: buffered features, then the bias
          if (iss_active) begin
            if (idx == BIAS_IDX) begin
              iss_active <= 1'b0;
            end else if (({1'b0, idx} + 1'b1) < {1'b0, count}) begin
              idx <= idx + 1'b1;
            end else begin
              idx <= BIAS_IDX;
            end
          end
          if (s2_valid && s2_bias) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_perceptron_train_predict_unit.sv -----
// Self-checking testbench for the perceptron train/predict unit: directed and random samples.
`default_nettype none

// Mirror of the perceptron: weights, feature buffer and running sum, plus the verdicts owed.
class perceptron_mirror;
  localparam int NUM_IN = ptp_pkg::NUM_INPUTS_DEF;
  localparam longint W_HI = (longint'(1) <<< 31) - 1;
  localparam longint W_LO = -(longint'(1) <<< 31);

  typedef struct packed {
    logic cls;
    logic changed;
    logic clipped;
  } verdict_t;

  longint weight [0:NUM_IN];
  logic signed [ptp_pkg::F_WIDTH-1:0] feat_hold [0:NUM_IN-1];
  int unsigned fill;
  longint acc;
  bit [ptp_pkg::RATE_WIDTH-1:0] rate;
  bit step_changed;
  bit step_clipped;
  verdict_t pending[$];
  int unsigned faults;

  function new();
    foreach (weight[i]) weight[i] = 0;
    fill = 0;
    acc = 0;
    rate = ptp_pkg::RATE_RESET;
    faults = 0;
  endfunction

  // Add one step to a weight, clip to the Q8.24 range, note change and clip
  function void bump(int idx, longint delta);
    longint nv;
    nv = weight[idx] + delta;
    if (nv > W_HI) begin
      nv = W_HI;
      step_clipped = 1'b1;
    end else if (nv < W_LO) begin
      nv = W_LO;
      step_clipped = 1'b1;
    end
    if (nv != weight[idx]) step_changed = 1'b1;
    weight[idx] = nv;
  endfunction

  // Account for one accepted input transfer; a last item owes one verdict
  function void absorb(logic o, logic signed [ptp_pkg::F_WIDTH-1:0] x, logic lab, logic lst);
    verdict_t v;
    longint err;
    if (fill < NUM_IN) begin
      feat_hold[fill] = x;
      acc += weight[fill] * longint'(x);
      fill++;
    end
    if (!lst) return;
    acc += weight[NUM_IN] * longint'(ptp_pkg::ONE_Q8_8);
    v.cls = (acc >= 0) ? ptp_pkg::CLASS_POS : ptp_pkg::CLASS_NEG;
    step_changed = 1'b0;
    step_clipped = 1'b0;
    // Train only on a miss; label minus class is then +2 or -2
    if (o == ptp_pkg::OP_TRAIN && lab != v.cls) begin
      err = (lab == ptp_pkg::CLASS_POS) ? 2 : -2;
      for (int i = 0; i < fill; i++)
        bump(i, longint'(rate) * longint'(feat_hold[i]) * err);
      bump(NUM_IN, longint'(rate) * longint'(ptp_pkg::ONE_Q8_8) * err);
    end
    v.changed = step_changed;
    v.clipped = step_clipped;
    pending.push_back(v);
    fill = 0;
    acc = 0;
  endfunction

  // Compare one result transfer with the oldest verdict owed
  function void compare(logic pc, logic wc, logic sat);
    verdict_t v;
    if (pending.size() == 0) begin
      $display("%0t: result with none expected: class %0b changed %0b saturated %0b",
               $time, pc, wc, sat);
      faults++;
      return;
    end
    v = pending.pop_front();
    if (pc !== v.cls) begin
      $display("%0t: predicted_class expected %0b actual %0b", $time, v.cls, pc);
      faults++;
    end
    if (wc !== v.changed) begin
      $display("%0t: weights_changed expected %0b actual %0b", $time, v.changed, wc);
      faults++;
    end
    if (sat !== v.clipped) begin
      $display("%0t: saturated expected %0b actual %0b", $time, v.clipped, sat);
      faults++;
    end
  endfunction
endclass

module tb_perceptron_train_predict_unit;
  import ptp_pkg::*;

  localparam int NUM_IN = NUM_INPUTS_DEF;
  localparam int DRAIN = 40;        // idle margin after the last result transfer
  localparam int LONG_HOLD = 300;
  localparam int STUCK_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [RATE_WIDTH-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic op;
  logic signed [F_WIDTH-1:0] feature;
  logic label;
  logic last;
  logic out_valid;
  logic out_ready;
  logic predicted_class;
  logic weights_changed;
  logic saturated;

  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned stuck = 0;
  perceptron_mirror mirror = new();

  perceptron_train_predict_unit #(.NUM_INPUTS(NUM_IN)) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .feature        (feature),
    .label          (label),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .predicted_class(predicted_class),
    .weights_changed(weights_changed),
    .saturated      (saturated)
  );

  always #4 clk = ~clk;

  // Check every result transfer
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) mirror.compare(predicted_class, weights_changed, saturated);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic signed [F_WIDTH-1:0] pick_feature();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3, 4, 5: v = int'($urandom_range(0, 65535)) - 32768;
      default: v = int'($urandom_range(0, 1024)) - 512;
    endcase
    return v[F_WIDTH-1:0];
  endfunction

  // Offer one item, possibly after an idle burst, and hold it until the transfer
  task automatic send_item(input logic o, input logic signed [F_WIDTH-1:0] x,
                           input logic lab, input logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = o;
    feature = x;
    label = lab;
    last = lst;
    do @(posedge clk); while (in_ready !== 1'b1);
    mirror.absorb(o, x, lab, lst);
  endtask

  // One sample of random features; half the labels follow the sign of the feature sum
  task automatic send_sample(input int len, input logic op_last);
    logic signed [F_WIDTH-1:0] feats[$];
    longint hidden;
    logic lab;
    hidden = 0;
    for (int i = 0; i < len; i++) begin
      feats.push_back(pick_feature());
      hidden += longint'(feats[i]);
    end
    lab = $urandom_range(0, 1) ? ((hidden >= 0) ? CLASS_POS : CLASS_NEG) : 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_item(op_last, feats[i], lab, 1'b1);
      else send_item(1'($urandom_range(0, 1)), feats[i], 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // Mostly full-size or short samples, some with too many features
  task automatic run_random(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(NUM_IN + 1, NUM_IN + 4);
      else len = $urandom_range(1, NUM_IN);
      send_sample(len, ($urandom_range(0, 3) == 0) ? OP_PREDICT : OP_TRAIN);
      sent += len;
    end
  endtask

  // Drop valid and wait until every result is in and the unit is idle
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_WIDTH-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    mirror.rate = v;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    op = OP_PREDICT;
    feature = '0;
    label = CLASS_NEG;
    last = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero sum gives +1, extremes, too many features, short sample
    send_item(OP_PREDICT, 16'sd0, CLASS_NEG, 1'b1);
    send_item(OP_TRAIN, 16'sh7fff, CLASS_NEG, 1'b1);
    send_item(OP_TRAIN, 16'sh8000, CLASS_NEG, 1'b1);
    for (int i = 0; i < NUM_IN + 2; i++)
      send_item(OP_TRAIN, i[0] ? 16'sh8000 : 16'sh7fff, CLASS_POS, i == NUM_IN + 1);
    send_item(OP_TRAIN, 16'sd256, CLASS_NEG, 1'b0);
    send_item(OP_TRAIN, -16'sd256, CLASS_POS, 1'b1);
    settle();

    // Full rate: one of the two opposite labels misses and clips a weight
    write_rate(16'hffff);
    send_item(OP_TRAIN, 16'sh7fff, CLASS_NEG, 1'b1);
    send_item(OP_TRAIN, 16'sh7fff, CLASS_POS, 1'b1);

    // Random phases over several rates, one with a long result-side hold
    long_hold_req = 1'b1;
    run_random(150);
    settle();
    write_rate(16'h0000);
    run_random(150);
    settle();
    write_rate(16'h0001);
    quiet = 1'b1;
    run_random(100);
    quiet = 1'b0;
    settle();
    write_rate(RATE_WIDTH'($urandom_range(2, 65534)));
    run_random(150);
    settle();
    write_rate(RATE_RESET);
    run_random(100);
    settle();
    write_rate(16'hffff);
    quiet = 1'b1;
    run_random(100);
    settle();

    if (mirror.faults == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/ptp_pkg.sv
rtl/perceptron_train_predict_unit.sv
verif/tb_perceptron_train_predict_unit.sv
